// ===== rtl/core/bcc_pkg.sv =====
// Shared types, codes and lookup functions for the six-step commutation block.
// Used by the channel interfaces and by bemf_commutation_controller_unit.
package bcc_pkg;

	localparam int TIMER_W = 16;
	localparam int LIMIT_W = 16;
	localparam int LEN_W   = 6;
	localparam int CFG_W   = 16;

	typedef logic [2:0]         phase_t;
	typedef logic [5:0]         drive_t;
	typedef logic [TIMER_W-1:0] timer_t;

	localparam phase_t PHASE_NONE = 3'd6;
	localparam phase_t PHASE_LAST = 3'd5;
	localparam drive_t DRIVE_OFF  = 6'd42;
	localparam timer_t TIMER_MAX  = '1;
	localparam logic [LIMIT_W-1:0] STALL_LIMIT_RST = 16'd1000;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_BEMF  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic {
		CFG_STALL_LIMIT = 1'b0,
		CFG_SCHED_LEN   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		drive_t drive_word;
		phase_t phase;
		logic   stall_flag;
	} result_t;

	// comparator pattern (U bit2, V bit1, W bit0) to phase
	function automatic phase_t decode_pattern(input logic [2:0] pat);
		phase_t p;
		case (pat)
			3'b110:  p = 3'd0;
			3'b100:  p = 3'd1;
			3'b101:  p = 3'd2;
			3'b001:  p = 3'd3;
			3'b011:  p = 3'd4;
			3'b010:  p = 3'd5;
			default: p = PHASE_NONE;
		endcase
		return p;
	endfunction

	// gate word for a phase: UH UL VH VL WH WL
	function automatic drive_t drive_of_phase(input phase_t p);
		drive_t d;
		case (p)
			3'd0:    d = 6'd11;
			3'd1:    d = 6'd14;
			3'd2:    d = 6'd44;
			3'd3:    d = 6'd56;
			3'd4:    d = 6'd50;
			3'd5:    d = 6'd35;
			default: d = DRIVE_OFF;
		endcase
		return d;
	endfunction

	// step modulo 6; the disabled code steps to 1
	function automatic phase_t next_phase(input phase_t p);
		phase_t n;
		case (p)
			PHASE_LAST: n = 3'd0;
			PHASE_NONE: n = 3'd1;
			default:    n = p + 3'd1;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/core/bcc_if.sv =====
// Valid/ready channel interfaces for the commutation block: event items in,
// status results out. Depends on bcc_pkg.
interface bcc_in_if;
	import bcc_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [2:0]  bemf_pattern;
	logic [4:0]  entry_index;
	timer_t      entry_time;

	modport source (output valid, func, bemf_pattern, entry_index, entry_time,
		input ready);
	modport sink (input valid, func, bemf_pattern, entry_index, entry_time,
		output ready);
endinterface

interface bcc_out_if;
	import bcc_pkg::*;
	logic   valid;
	logic   ready;
	drive_t drive_word;
	phase_t phase;
	logic   stall_flag;

	modport source (output valid, drive_word, phase, stall_flag, input ready);
	modport sink (input valid, drive_word, phase, stall_flag, output ready);
endinterface

// ===== rtl/core/bcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read during write to the same address returns old data.
module bcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/bemf_commutation_controller_unit.sv =====
// Six-step BLDC commutation controller with open-loop spin-up.
// Depends on bcc_pkg, bcc_if (channel interfaces) and bcc_ram.
//
// Usage: every item on "items" is one event: a 100 us tick, a back-EMF
// comparator change, a write of one spin-up schedule entry, or no operation.
// Every item yields exactly one result on "results": the gate word, the
// phase and the stall flag after that item took effect.
// Throughput is one item per clock while ready is high: all state updates
// in the accept cycle. The schedule lives in a RAM whose read address
// follows the next spin step, so the entry needed by the next tick is
// already at the RAM output; a write to that same entry is forwarded. A
// two-entry output buffer (output register plus skid stage) takes each
// result and lets the block accept while a result waits; ready drops only
// when both hold results, which with back-to-back items is the cycle after
// the first cycle of receiver stall. Configuration (stall_limit,
// schedule_length) is written through cfg_we, cfg_index and cfg_data by
// the user only while the block is idle; the block does not enforce it.
// Reset: phase 6, gates off, stalled with an empty schedule, so the first
// tick ends spin-up. Schedule contents are undefined until written; no
// clearing pass is run, the block is ready right after reset.
module bemf_commutation_controller_unit #(
	parameter int SCHED_DEPTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	bcc_in_if.sink                  items,
	bcc_out_if.source               results,
	input  logic                    cfg_we,
	input  bcc_pkg::cfg_idx_t       cfg_index,
	input  logic [bcc_pkg::CFG_W-1:0] cfg_data
);
	import bcc_pkg::*;

	localparam int AW = (SCHED_DEPTH > 1) ? $clog2(SCHED_DEPTH) : 1;
	localparam int SW = $clog2(SCHED_DEPTH + 1);

	// configuration
	logic [LIMIT_W-1:0] stall_limit_q;
	logic [LEN_W-1:0]   sched_len_q;

	// control state
	phase_t             phase_q, phase_d;
	logic               stalled_q, stalled_d;
	timer_t             comm_q, comm_d;
	timer_t             spin_q, spin_d;
	logic [SW-1:0]      step_q, step_d;

	// schedule RAM and forwarding
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	timer_t             ram_rdata;
	logic               fwd_q;
	timer_t             fwd_data_q;
	timer_t             sched_cur;

	// tick arithmetic
	logic [SW-1:0]      len_eff;
	timer_t             comm_inc, spin_inc, spin_t;
	logic [SW-1:0]      step_t;
	logic               declare, advance;

	// output buffer
	logic               accept, pop;
	result_t            res_new, out_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	assign accept = items.valid && items.ready;
	assign pop    = results.valid && results.ready;
	assign items.ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_limit_q <= STALL_LIMIT_RST;
			sched_len_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STALL_LIMIT: stall_limit_q <= cfg_data;
				CFG_SCHED_LEN:   sched_len_q   <= cfg_data[LEN_W-1:0];
				default:         ;
			endcase
		end
	end

	assign len_eff = (32'(sched_len_q) > SCHED_DEPTH) ? SW'(SCHED_DEPTH) : SW'(sched_len_q);

	// schedule[step] while stalled, schedule[0] otherwise
	assign sched_cur = fwd_q ? fwd_data_q : ram_rdata;

	assign comm_inc = (comm_q == TIMER_MAX) ? comm_q : comm_q + 1'b1;
	assign spin_inc = (spin_q == TIMER_MAX) ? spin_q : spin_q + 1'b1;
	assign declare  = !stalled_q && (comm_inc > stall_limit_q);
	assign spin_t   = declare ? '0 : spin_inc;
	assign step_t   = declare ? '0 : step_q;
	assign advance  = (step_t < len_eff) && (spin_t >= sched_cur);

	always_comb begin
		phase_d   = phase_q;
		stalled_d = stalled_q;
		comm_d    = comm_q;
		spin_d    = spin_q;
		step_d    = step_q;
		ram_we    = 1'b0;
		if (accept) begin
			unique case (func_t'(items.func))
				FUNC_TICK: begin
					comm_d = comm_inc;
					spin_d = spin_t;
					step_d = step_t;
					if (stalled_q || declare) begin
						stalled_d = 1'b1;
						if (advance) begin
							phase_d = next_phase(phase_q);
							step_d  = step_t + 1'b1;
						end
						// schedule used up: resume closed loop
						if (step_d >= len_eff) begin
							stalled_d = 1'b0;
							comm_d    = '0;
						end
					end
				end
				FUNC_BEMF: begin
					if (!stalled_q) begin
						comm_d  = '0;
						phase_d = decode_pattern(items.bemf_pattern);
					end
				end
				FUNC_WRITE: ram_we = 32'(items.entry_index) < SCHED_DEPTH;
				FUNC_NONE:  ;
				default:    ;
			endcase
		end
	end

	assign ram_waddr = AW'(items.entry_index);
	assign ram_raddr = stalled_d ? AW'(step_d) : '0;

	bcc_ram #(
		.WIDTH (TIMER_W),
		.DEPTH (SCHED_DEPTH)
	) u_sched_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (items.entry_time),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_NONE;
			stalled_q <= 1'b1;
			comm_q    <= '0;
			spin_q    <= '0;
			step_q    <= '0;
			fwd_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			stalled_q <= stalled_d;
			comm_q    <= comm_d;
			spin_q    <= spin_d;
			step_q    <= step_d;
			// RAM returns old data on a same-address write; take the new word
			fwd_q     <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= items.entry_time;
	end

	assign res_new.drive_word = drive_of_phase(phase_d);
	assign res_new.phase      = phase_d;
	assign res_new.stall_flag = stalled_d;

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_valid_q ? skid_q : res_new;
		end else if (accept && !out_valid_q) begin
			out_q <= res_new;
		end
		if (accept && out_valid_q && !pop) begin
			skid_q <= res_new;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.drive_word = out_q.drive_word;
	assign results.phase      = out_q.phase;
	assign results.stall_flag = out_q.stall_flag;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds an item while output register is empty");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_NONE)
		else $error("phase register out of range");

	a_resume_clears_timer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stalled_q) |-> (comm_q == '0))
		else $error("commutation timer not cleared when spin-up ended");

	a_stall_starts_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stalled_q) |-> (step_q <= SW'(1)) && (spin_q == '0))
		else $error("spin-up did not restart from the first entry");
`endif

endmodule
